// ===== src/crg_pkg.sv =====
// Shared types, constants and functions of the color gradient ramp.
`default_nettype none

package crg_pkg;

  // Stop table and palette sizing.
  localparam int NUM_STOPS   = 10;
  localparam int MAX_ENTRIES = 1024;

  // Field widths.
  localparam int POS_W        = 17;
  localparam int CH_W         = 8;
  localparam int RGB_W        = 3 * CH_W;
  localparam int STOP_FIELD_W = 4;
  localparam int ENTRY_W      = 10;
  localparam int ENT_W        = 11;

  // Derived widths.
  localparam int STOP_IDX_W   = $clog2(NUM_STOPS);
  localparam int NM1_W        = $clog2(MAX_ENTRIES);
  localparam int CNT_W        = $clog2(NUM_STOPS + 1);
  localparam int KEY_W        = 1 + POS_W + STOP_IDX_W;
  localparam int DIV_W        = POS_W;
  localparam int FI_QUOT_W    = POS_W;
  localparam int BLEND_QUOT_W = CH_W;
  localparam int PROD_W       = CH_W + POS_W;
  localparam int ACC_W        = PROD_W + 1;
  localparam int STEP_W       = ($clog2(FI_QUOT_W) > STOP_IDX_W) ? $clog2(FI_QUOT_W)
                                                                 : STOP_IDX_W;

  // Q1.16 one.
  localparam int ONE_Q16 = 65536;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = ENT_W;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERP_MODE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_ENTRIES = 1'd1;
  localparam logic             MODE_RESET    = 1'b1;
  localparam logic [ENT_W-1:0] ENTRIES_RESET = 11'd101;

  // Opcodes of an input beat.
  localparam logic OP_WRITE_STOP = 1'b0;
  localparam logic OP_PALETTE    = 1'b1;

  // Color channel being blended.
  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2
  } ch_e;

  // Input beat.
  typedef struct packed {
    logic                    opcode;
    logic [STOP_FIELD_W-1:0] stop_index;
    logic [POS_W-1:0]        stop_position;
    logic [CH_W-1:0]         stop_red;
    logic [CH_W-1:0]         stop_green;
    logic [CH_W-1:0]         stop_blue;
    logic [ENTRY_W-1:0]      entry_index;
  } crg_in_t;

  // Result beat.
  typedef struct packed {
    logic [ENTRY_W-1:0] out_index;
    logic [CH_W-1:0]    out_red;
    logic [CH_W-1:0]    out_green;
    logic [CH_W-1:0]    out_blue;
    logic               degenerate_segment;
  } crg_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                  stop_write;
    logic                  req_load;
    logic                  div_step;
    logic                  fi_save;
    logic                  scan_init;
    logic                  scan_en;
    logic [STOP_IDX_W-1:0] scan_idx;
    logic                  rd_left;
    logic                  rd_right;
    logic                  eval;
    logic                  mul;
    logic                  blend_load;
    logic                  blend_save;
    ch_e                   ch;
    logic                  out_load;
  } crg_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_palette;
    logic use_blend;
  } crg_status_t;

  // Reset position of stop k: floor(k * 1.0 / (NUM_STOPS - 1)) in Q1.16.
  function automatic logic [POS_W-1:0] stop_reset_pos(input int k);
    return POS_W'((k * ONE_Q16) / (NUM_STOPS - 1));
  endfunction

endpackage

`default_nettype wire

// ===== src/crg_divider.sv =====
// Radix-2 restoring divider that produces one quotient bit per step.
`default_nettype none

module crg_divider (
  input  wire logic                      clk_i,
  input  wire logic                      load_i,
  input  wire logic                      step_i,
  input  wire logic [crg_pkg::DIV_W-1:0] rem_init_i,
  input  wire logic [crg_pkg::DIV_W-1:0] num_init_i,
  input  wire logic [crg_pkg::DIV_W-1:0] den_i,
  output logic      [crg_pkg::DIV_W-1:0] quot_o
);

  logic [crg_pkg::DIV_W-1:0] rem_q, rem_d;
  logic [crg_pkg::DIV_W-1:0] num_q, num_d;
  logic [crg_pkg::DIV_W-1:0] den_q;
  logic [crg_pkg::DIV_W:0]   trial;
  logic                      qbit;

  // One step: shift the next dividend bit into the partial remainder and
  // subtract the divisor when it fits. Quotient bits enter at the bottom.
  always_comb begin
    trial = {rem_q, num_q[crg_pkg::DIV_W-1]};
    qbit  = (trial >= {1'b0, den_q});
    rem_d = qbit ? crg_pkg::DIV_W'(trial - {1'b0, den_q})
                 : crg_pkg::DIV_W'(trial);
    num_d = {num_q[crg_pkg::DIV_W-2:0], qbit};
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rem_q <= rem_init_i;
      num_q <= num_init_i;
      den_q <= den_i;
    end else if (step_i) begin
      rem_q <= rem_d;
      num_q <= num_d;
    end
  end

  assign quot_o = num_q;

endmodule

`default_nettype wire

// ===== src/crg_datapath.sv =====
// Datapath: stop tables, configuration, stop scan, blend and result register.
`default_nettype none

module crg_datapath (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire crg_pkg::crg_in_t               in_data_i,
  input  wire logic                           cfg_we_i,
  input  wire logic [crg_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [crg_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire crg_pkg::crg_cmd_t              cmd_i,
  output crg_pkg::crg_status_t                status_o,
  output crg_pkg::crg_out_t                   out_data_o
);

  localparam int KP_HI = crg_pkg::STOP_IDX_W + crg_pkg::POS_W - 1;
  localparam int KP_LO = crg_pkg::STOP_IDX_W;

  // Configuration and stop tables.
  logic                      mode_q;
  logic [crg_pkg::ENT_W-1:0] entries_q;
  logic [crg_pkg::POS_W-1:0] pos_q   [crg_pkg::NUM_STOPS];
  logic [crg_pkg::RGB_W-1:0] color_q [crg_pkg::NUM_STOPS];

  // Request working registers.
  logic [crg_pkg::ENTRY_W-1:0] idx_q;
  logic [crg_pkg::POS_W-1:0]   fi_q;
  logic [crg_pkg::CNT_W-1:0]   cnt_le_q;
  logic [crg_pkg::KEY_W-1:0]   lo_key_q, hi_key_q;
  logic [crg_pkg::KEY_W-1:0]   min1_q, min2_q, max1_q, max2_q;
  logic [crg_pkg::RGB_W-1:0]   cl_q, cr_q, rgb_q;
  logic [crg_pkg::POS_W-1:0]   pl_q, pr_q, d_q, u_q, dmu_q;
  logic                        degen_q;
  logic [crg_pkg::PROD_W-1:0]  prod_l_q, prod_r_q;
  crg_pkg::crg_out_t           out_q;

  // Request setup: palette size clamp, entry clamp and stop position clamp.
  logic [crg_pkg::NM1_W-1:0]   nm1;
  logic [crg_pkg::ENTRY_W-1:0] idx_sat;
  logic [crg_pkg::POS_W-1:0]   wr_pos;

  always_comb begin
    if (entries_q < crg_pkg::ENT_W'(2)) begin
      nm1 = crg_pkg::NM1_W'(1);
    end else if (32'(entries_q) > crg_pkg::MAX_ENTRIES) begin
      nm1 = crg_pkg::NM1_W'(crg_pkg::MAX_ENTRIES - 1);
    end else begin
      nm1 = crg_pkg::NM1_W'(entries_q - crg_pkg::ENT_W'(1));
    end
    if (32'(in_data_i.entry_index) > 32'(nm1)) begin
      idx_sat = crg_pkg::ENTRY_W'(nm1);
    end else begin
      idx_sat = in_data_i.entry_index;
    end
    if (in_data_i.stop_position > crg_pkg::POS_W'(crg_pkg::ONE_Q16)) begin
      wr_pos = crg_pkg::POS_W'(crg_pkg::ONE_Q16);
    end else begin
      wr_pos = in_data_i.stop_position;
    end
  end

  // Configuration writes and stop writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= crg_pkg::MODE_RESET;
      entries_q <= crg_pkg::ENTRIES_RESET;
      for (int k = 0; k < crg_pkg::NUM_STOPS; k++) begin
        pos_q[k]   <= crg_pkg::stop_reset_pos(k);
        color_q[k] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          crg_pkg::CFG_INTERP_MODE:   mode_q    <= cfg_data_i[0];
          crg_pkg::CFG_TABLE_ENTRIES: entries_q <= cfg_data_i;
        endcase
      end
      if (cmd_i.stop_write) begin
        for (int k = 0; k < crg_pkg::NUM_STOPS; k++) begin
          if (32'(in_data_i.stop_index) == k) begin
            pos_q[k]   <= wr_pos;
            color_q[k] <= {in_data_i.stop_red, in_data_i.stop_green, in_data_i.stop_blue};
          end
        end
      end
    end
  end

  // Scan of one stop: its sort key is position, then stop number.
  logic [crg_pkg::POS_W-1:0] scan_pos;
  logic [crg_pkg::KEY_W-1:0] scan_key;
  logic                      scan_le;

  assign scan_pos = pos_q[cmd_i.scan_idx];
  assign scan_key = {1'b1, scan_pos, cmd_i.scan_idx};
  assign scan_le  = (scan_pos <= fi_q);

  // Bracketing pair, clamped to the first or last segment.
  logic [crg_pkg::KEY_W-1:0]      sel_left, sel_right;
  logic [crg_pkg::STOP_IDX_W-1:0] rd_idx;

  always_comb begin
    if (cnt_le_q == '0) begin
      sel_left  = min1_q;
      sel_right = min2_q;
    end else if (cnt_le_q == crg_pkg::CNT_W'(crg_pkg::NUM_STOPS)) begin
      sel_left  = max2_q;
      sel_right = max1_q;
    end else begin
      sel_left  = lo_key_q;
      sel_right = hi_key_q;
    end
    rd_idx = cmd_i.rd_right ? sel_right[crg_pkg::STOP_IDX_W-1:0]
                            : sel_left[crg_pkg::STOP_IDX_W-1:0];
  end

  // Segment evaluation: span, clamped offset and nearest-stop choice.
  logic [crg_pkg::POS_W-1:0] seg_d, seg_u;
  logic [crg_pkg::POS_W:0]   pos_sum;
  logic                      near_left, seg_degen;

  always_comb begin
    seg_degen = (pr_q <= pl_q);
    seg_d     = pr_q - pl_q;
    seg_u     = (fi_q <= pl_q) ? '0 : (fi_q - pl_q);
    if (seg_u > seg_d) begin
      seg_u = seg_d;
    end
    pos_sum   = {1'b0, pl_q} + {1'b0, pr_q};
    near_left = ({fi_q, 1'b0} < pos_sum);
  end

  // Channel selection for the blend multipliers.
  logic [crg_pkg::CH_W-1:0] ch_l, ch_r;

  always_comb begin
    unique case (cmd_i.ch)
      crg_pkg::CH_RED: begin
        ch_l = cl_q[23:16];
        ch_r = cr_q[23:16];
      end
      crg_pkg::CH_GREEN: begin
        ch_l = cl_q[15:8];
        ch_r = cr_q[15:8];
      end
      default: begin
        ch_l = cl_q[7:0];
        ch_r = cr_q[7:0];
      end
    endcase
  end

  // Shared divider: palette position first, then each blended channel.
  logic [crg_pkg::ACC_W-1:0] acc;
  logic [crg_pkg::DIV_W-1:0] div_rem_init, div_num_init, div_den, div_quot;

  always_comb begin
    acc = crg_pkg::ACC_W'(prod_l_q) + crg_pkg::ACC_W'(prod_r_q) + crg_pkg::ACC_W'(d_q >> 1);
    if (cmd_i.req_load) begin
      div_rem_init = crg_pkg::DIV_W'(idx_sat);
      div_num_init = crg_pkg::DIV_W'(nm1);
      div_den      = crg_pkg::DIV_W'({nm1, 1'b0});
    end else begin
      div_rem_init = acc[crg_pkg::PROD_W-1:crg_pkg::CH_W];
      div_num_init = crg_pkg::DIV_W'(acc[crg_pkg::CH_W-1:0]) << (crg_pkg::DIV_W - crg_pkg::CH_W);
      div_den      = d_q;
    end
  end

  crg_divider u_divider (
    .clk_i      (clk_i),
    .load_i     (cmd_i.req_load | cmd_i.blend_load),
    .step_i     (cmd_i.div_step),
    .rem_init_i (div_rem_init),
    .num_init_i (div_num_init),
    .den_i      (div_den),
    .quot_o     (div_quot)
  );

  // Working registers of one palette request.
  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) begin
      idx_q <= idx_sat;
    end
    if (cmd_i.fi_save) begin
      fi_q <= div_quot;
    end
    if (cmd_i.scan_init) begin
      cnt_le_q <= '0;
      lo_key_q <= '0;
      hi_key_q <= '1;
      min1_q   <= '1;
      min2_q   <= '1;
      max1_q   <= '0;
      max2_q   <= '0;
    end else if (cmd_i.scan_en) begin
      if (scan_le) begin
        cnt_le_q <= cnt_le_q + crg_pkg::CNT_W'(1);
        if (scan_key > lo_key_q) begin
          lo_key_q <= scan_key;
        end
      end else if (scan_key < hi_key_q) begin
        hi_key_q <= scan_key;
      end
      if (scan_key < min1_q) begin
        min2_q <= min1_q;
        min1_q <= scan_key;
      end else if (scan_key < min2_q) begin
        min2_q <= scan_key;
      end
      if (scan_key > max1_q) begin
        max2_q <= max1_q;
        max1_q <= scan_key;
      end else if (scan_key > max2_q) begin
        max2_q <= scan_key;
      end
    end
    if (cmd_i.rd_left) begin
      cl_q <= color_q[rd_idx];
      pl_q <= sel_left[KP_HI:KP_LO];
    end
    if (cmd_i.rd_right) begin
      cr_q <= color_q[rd_idx];
      pr_q <= sel_right[KP_HI:KP_LO];
    end
    if (cmd_i.eval) begin
      degen_q <= seg_degen;
      d_q     <= seg_d;
      u_q     <= seg_u;
      dmu_q   <= seg_d - seg_u;
      rgb_q   <= (seg_degen || near_left) ? cl_q : cr_q;
    end
    if (cmd_i.mul) begin
      prod_l_q <= crg_pkg::PROD_W'(ch_l) * crg_pkg::PROD_W'(dmu_q);
      prod_r_q <= crg_pkg::PROD_W'(ch_r) * crg_pkg::PROD_W'(u_q);
    end
    if (cmd_i.blend_save) begin
      unique case (cmd_i.ch)
        crg_pkg::CH_RED:   rgb_q[23:16] <= div_quot[crg_pkg::CH_W-1:0];
        crg_pkg::CH_GREEN: rgb_q[15:8]  <= div_quot[crg_pkg::CH_W-1:0];
        default:           rgb_q[7:0]   <= div_quot[crg_pkg::CH_W-1:0];
      endcase
    end
    if (cmd_i.out_load) begin
      out_q.out_index          <= idx_q;
      out_q.out_red            <= rgb_q[23:16];
      out_q.out_green          <= rgb_q[15:8];
      out_q.out_blue           <= rgb_q[7:0];
      out_q.degenerate_segment <= degen_q;
    end
  end

  assign status_o.is_palette = (in_data_i.opcode == crg_pkg::OP_PALETTE);
  assign status_o.use_blend  = mode_q && !seg_degen;
  assign out_data_o          = out_q;

  // The bracketing pair is always in sort order.
  a_pair_ordered : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_left |-> (sel_left < sel_right))
    else $error("bracketing stops out of order");

  // A blended channel quotient never overflows the channel width.
  a_blend_fits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.blend_save |-> (div_quot[crg_pkg::DIV_W-1:crg_pkg::CH_W] == '0))
    else $error("blend quotient overflows a channel");

endmodule

`default_nettype wire

// ===== src/crg_ctrl.sv =====
// Controller state machine that sequences one beat through the datapath.
`default_nettype none

module crg_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  input  wire crg_pkg::crg_status_t status_i,
  output crg_pkg::crg_cmd_t         cmd_o
);

  typedef enum logic [11:0] {
    S_IDLE    = 12'b0000_0000_0001,
    S_FI_DIV  = 12'b0000_0000_0010,
    S_FI_SAVE = 12'b0000_0000_0100,
    S_SCAN    = 12'b0000_0000_1000,
    S_RD_L    = 12'b0000_0001_0000,
    S_RD_R    = 12'b0000_0010_0000,
    S_EVAL    = 12'b0000_0100_0000,
    S_MUL     = 12'b0000_1000_0000,
    S_BLOAD   = 12'b0001_0000_0000,
    S_BDIV    = 12'b0010_0000_0000,
    S_BSAVE   = 12'b0100_0000_0000,
    S_FINISH  = 12'b1000_0000_0000
  } state_e;

  state_e                     state_q, state_d;
  logic [crg_pkg::STEP_W-1:0] cnt_q, cnt_d;
  crg_pkg::ch_e               ch_q, ch_d;
  logic                       out_valid_q, out_valid_d;
  logic                       out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // Next state, step counter and datapath commands.
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    ch_d         = ch_q;
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    cmd_o.scan_idx = cnt_q[crg_pkg::STOP_IDX_W-1:0];
    cmd_o.ch     = ch_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (status_i.is_palette) begin
            cmd_o.req_load = 1'b1;
            cnt_d          = '0;
            state_d        = S_FI_DIV;
          end else begin
            cmd_o.stop_write = 1'b1;
          end
        end
      end
      S_FI_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == crg_pkg::STEP_W'(crg_pkg::FI_QUOT_W - 1)) begin
          cnt_d   = '0;
          state_d = S_FI_SAVE;
        end else begin
          cnt_d = cnt_q + crg_pkg::STEP_W'(1);
        end
      end
      S_FI_SAVE: begin
        cmd_o.fi_save   = 1'b1;
        cmd_o.scan_init = 1'b1;
        state_d         = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan_en = 1'b1;
        if (cnt_q == crg_pkg::STEP_W'(crg_pkg::NUM_STOPS - 1)) begin
          cnt_d   = '0;
          state_d = S_RD_L;
        end else begin
          cnt_d = cnt_q + crg_pkg::STEP_W'(1);
        end
      end
      S_RD_L: begin
        cmd_o.rd_left = 1'b1;
        state_d       = S_RD_R;
      end
      S_RD_R: begin
        cmd_o.rd_right = 1'b1;
        state_d        = S_EVAL;
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        if (status_i.use_blend) begin
          ch_d    = crg_pkg::CH_RED;
          state_d = S_MUL;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_BLOAD;
      end
      S_BLOAD: begin
        cmd_o.blend_load = 1'b1;
        cnt_d            = '0;
        state_d          = S_BDIV;
      end
      S_BDIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == crg_pkg::STEP_W'(crg_pkg::BLEND_QUOT_W - 1)) begin
          cnt_d   = '0;
          state_d = S_BSAVE;
        end else begin
          cnt_d = cnt_q + crg_pkg::STEP_W'(1);
        end
      end
      S_BSAVE: begin
        cmd_o.blend_save = 1'b1;
        unique case (ch_q)
          crg_pkg::CH_RED: begin
            ch_d    = crg_pkg::CH_GREEN;
            state_d = S_MUL;
          end
          crg_pkg::CH_GREEN: begin
            ch_d    = crg_pkg::CH_BLUE;
            state_d = S_MUL;
          end
          default: begin
            state_d = S_FINISH;
          end
        endcase
      end
      S_FINISH: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Result register occupancy.
  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      ch_q        <= crg_pkg::CH_RED;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ch_q        <= ch_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // A palette beat starts the position division in the next cycle.
  a_palette_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && status_i.is_palette) |=> (state_q == S_FI_DIV))
    else $error("palette beat did not start the division");

  // A stop write completes in its own cycle and leaves the block ready.
  a_write_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !status_i.is_palette) |=> (state_q == S_IDLE))
    else $error("stop write left the idle state");

  // A new result never overwrites one that is still waiting.
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten");

endmodule

`default_nettype wire

// ===== src/color_gradient_ramp.sv =====
// Top level of the color gradient ramp: controller, datapath and ports.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_ready_o    in_data_i  (crg_in_t)
//   out      output     out_valid_o / out_ready_i  out_data_o (crg_out_t)
//   cfg      input      cfg_we_i                   cfg_index_i, cfg_data_i
//
// A stop write is stored at once; the block is ready again in the next cycle.
// A palette beat reaches the result register through a 17-bit division on
// the serial divider for the palette position and a scan of the stops; in
// blend mode, unless the segment is degenerate, three 8-bit divisions for
// the blended channels follow on the same divider.
// A new beat is taken while a result waits; a result that is not taken holds
// the next one in its final state. Reset is asynchronous and needs no sweep.
`default_nettype none

module color_gradient_ramp (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire crg_pkg::crg_in_t               in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output crg_pkg::crg_out_t                   out_data_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [crg_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [crg_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  crg_pkg::crg_cmd_t    cmd;
  crg_pkg::crg_status_t status;

  // Sequencing of each beat.
  crg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Tables, arithmetic and result register.
  crg_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== verif/crg_checker.sv =====
// Checker for the color gradient ramp: mirrors stops and settings, predicts and compares colors.
`timescale 1ns / 100ps

module crg_checker
  import crg_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  crg_in_t               in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  crg_out_t              out_data_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    mismatch_count_o,
  output int                    pending_o
);

  localparam int REPORT_LIMIT = 10;

  // Mirror of the stop table and the two settings.
  logic [POS_W-1:0] stop_pos [NUM_STOPS];
  logic [RGB_W-1:0] stop_rgb [NUM_STOPS];
  logic             blend_on;
  logic [ENT_W-1:0] palette_size;

  // Colors of palette requests that have been taken but not yet returned.
  crg_out_t colors_due [$];
  crg_out_t due_color;

  // Rounded linear blend of one channel; u is already clamped to [0, d].
  function automatic logic [CH_W-1:0] mix_channel(input logic [CH_W-1:0] left_ch,
                                                  input logic [CH_W-1:0] right_ch,
                                                  input longint unsigned u,
                                                  input longint unsigned d);
    longint unsigned acc;
    acc = left_ch * (d - u) + right_ch * u + d / 2;
    return CH_W'(acc / d);
  endfunction

  // Expected color of one palette entry under the current stops and settings.
  function automatic crg_out_t predict_color(input logic [ENTRY_W-1:0] entry_raw);
    longint unsigned n, idx, fi, pl, pr, d, u;
    longint          dl, dr;
    int              order [NUM_STOPS];
    int              cnt, j, k, seg, lft, rgt;
    logic [RGB_W-1:0] cl, cr, rgb;
    crg_out_t        res;
    n = palette_size;
    if (n < 2) n = 2;
    if (n > MAX_ENTRIES) n = MAX_ENTRIES;
    idx = entry_raw;
    if (idx > n - 1) idx = n - 1;
    fi = (idx * ONE_Q16 * 2 + (n - 1)) / (2 * (n - 1));

    // Stable insertion sort of stop numbers by position.
    for (k = 0; k < NUM_STOPS; k++) begin
      j = k;
      while (j > 0 && stop_pos[order[j-1]] > stop_pos[k]) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = k;
    end

    // Left stop is the last one not above fi, clamped to the end segments.
    cnt = 0;
    for (k = 0; k < NUM_STOPS; k++) begin
      if (stop_pos[order[k]] <= fi) cnt++;
    end
    seg = cnt - 1;
    if (seg < 0) seg = 0;
    if (seg > NUM_STOPS - 2) seg = NUM_STOPS - 2;
    lft = order[seg];
    rgt = order[seg+1];
    pl  = stop_pos[lft];
    pr  = stop_pos[rgt];
    cl  = stop_rgb[lft];
    cr  = stop_rgb[rgt];

    res = '0;
    if (pr <= pl) begin
      res.degenerate_segment = 1'b1;
      rgb = cl;
    end else if (blend_on) begin
      d = pr - pl;
      u = (fi <= pl) ? 0 : fi - pl;
      if (u > d) u = d;
      rgb = {mix_channel(cl[2*CH_W +: CH_W], cr[2*CH_W +: CH_W], u, d),
             mix_channel(cl[CH_W +: CH_W], cr[CH_W +: CH_W], u, d),
             mix_channel(cl[0 +: CH_W], cr[0 +: CH_W], u, d)};
    end else begin
      // Nearest stop; a tie goes to the right stop.
      dl  = longint'(fi) - longint'(pl);
      dr  = longint'(pr) - longint'(fi);
      rgb = (dl < dr) ? cl : cr;
    end
    res.out_index = ENTRY_W'(idx);
    res.out_red   = rgb[2*CH_W +: CH_W];
    res.out_green = rgb[CH_W +: CH_W];
    res.out_blue  = rgb[0 +: CH_W];
    return res;
  endfunction

  // Track settings and stops, check results, queue new predictions.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_STOPS; k++) begin
        stop_pos[k] = POS_W'((k * ONE_Q16) / (NUM_STOPS - 1));
        stop_rgb[k] = '0;
      end
      blend_on         = MODE_RESET;
      palette_size     = ENTRIES_RESET;
      colors_due.delete();
      mismatch_count_o = 0;
      pending_o        = 0;
    end else begin
      // Register writes.
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_INTERP_MODE) begin
          blend_on = cfg_data_i[0];
        end else if (cfg_index_i == CFG_TABLE_ENTRIES) begin
          palette_size = cfg_data_i;
        end
      end

      // A result beat is checked against the oldest waiting prediction.
      if (out_valid_i && out_ready_i) begin
        if (colors_due.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= REPORT_LIMIT) begin
            $display("%0t: unexpected result beat, entry %0d rgb %02x%02x%02x degenerate %0b",
                     $realtime, out_data_i.out_index, out_data_i.out_red,
                     out_data_i.out_green, out_data_i.out_blue, out_data_i.degenerate_segment);
          end
        end else begin
          due_color = colors_due.pop_front();
          if (out_data_i.out_index !== due_color.out_index ||
              out_data_i.out_red !== due_color.out_red ||
              out_data_i.out_green !== due_color.out_green ||
              out_data_i.out_blue !== due_color.out_blue ||
              out_data_i.degenerate_segment !== due_color.degenerate_segment) begin
            mismatch_count_o++;
            if (mismatch_count_o <= REPORT_LIMIT) begin
              $display("%0t: color mismatch: expected entry %0d rgb %02x%02x%02x degenerate %0b",
                       $realtime, due_color.out_index, due_color.out_red,
                       due_color.out_green, due_color.out_blue, due_color.degenerate_segment);
              $display("%0t:                 got      entry %0d rgb %02x%02x%02x degenerate %0b",
                       $realtime, out_data_i.out_index, out_data_i.out_red,
                       out_data_i.out_green, out_data_i.out_blue,
                       out_data_i.degenerate_segment);
            end
          end
        end
      end

      // A request beat either updates a stop or queues a palette color.
      if (in_valid_i && in_ready_i) begin
        if (in_data_i.opcode == OP_PALETTE) begin
          colors_due.push_back(predict_color(in_data_i.entry_index));
        end else if (in_data_i.stop_index < NUM_STOPS) begin
          stop_pos[in_data_i.stop_index] = (in_data_i.stop_position > ONE_Q16) ?
                                           POS_W'(ONE_Q16) : in_data_i.stop_position;
          stop_rgb[in_data_i.stop_index] = {in_data_i.stop_red, in_data_i.stop_green,
                                            in_data_i.stop_blue};
        end
      end
      pending_o = colors_due.size();
    end
  end

endmodule

// ===== verif/testbench.sv =====
// Testbench top: drives the color gradient ramp, paces both channels and gives the verdict.
`timescale 1ns / 100ps

module testbench;
  import crg_pkg::*;

  localparam int IDLE_SETTLE_CYCLES = 80;
  localparam int HOLD_OFF_CYCLES    = 300;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  crg_in_t               in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  crg_out_t              out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  int                    mismatches;
  int                    pending;

  // Pacing knobs shared by the feeding and draining processes.
  int                    feed_idle_pct = 30;
  int                    sink_idle_pct = 30;
  bit                    flood_req     = 1'b0;
  logic [POS_W-1:0]      recent_pos    = '0;

  always #5 clk = ~clk;

  color_gradient_ramp u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  crg_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_data_i       (out_data),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  // Idle stretch length: mostly short, a few long.
  function automatic int gap_cycles();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic crg_in_t stop_beat(input int idx, input int pos, input logic [7:0] red,
                                        input logic [7:0] green, input logic [7:0] blue);
    crg_in_t beat;
    beat               = '0;
    beat.opcode        = OP_WRITE_STOP;
    beat.stop_index    = STOP_FIELD_W'(idx);
    beat.stop_position = POS_W'(pos);
    beat.stop_red      = red;
    beat.stop_green    = green;
    beat.stop_blue     = blue;
    return beat;
  endfunction

  function automatic crg_in_t entry_beat(input int entry);
    crg_in_t beat;
    beat             = '0;
    beat.opcode      = OP_PALETTE;
    beat.entry_index = ENTRY_W'(entry);
    return beat;
  endfunction

  // Random beat: stop writes lean toward shared and edge positions so that
  // coincident stops and clamped segments come up often.
  function automatic crg_in_t random_beat(input int n_eff);
    crg_in_t beat;
    int      roll;
    beat = $bits(crg_in_t)'({$urandom, $urandom});
    roll = $urandom_range(0, 99);
    if (roll < 35) begin
      beat.opcode = OP_WRITE_STOP;
      if ($urandom_range(0, 9) != 0) beat.stop_index = STOP_FIELD_W'($urandom_range(0, NUM_STOPS - 1));
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
        beat.stop_position = POS_W'($urandom_range(0, ONE_Q16));
      end else if (roll < 60) begin
        case ($urandom_range(0, 4))
          0:       beat.stop_position = '0;
          1:       beat.stop_position = POS_W'(ONE_Q16);
          2:       beat.stop_position = POS_W'(ONE_Q16 / 2);
          3:       beat.stop_position = POS_W'(ONE_Q16 / 4);
          default: beat.stop_position = POS_W'(3 * ONE_Q16 / 4);
        endcase
      end else if (roll < 75) begin
        beat.stop_position = recent_pos;
      end else if (roll < 85) begin
        beat.stop_position = POS_W'($urandom_range(ONE_Q16 + 1, 2 * ONE_Q16 - 1));
      end
      recent_pos = beat.stop_position;
    end else begin
      beat.opcode = OP_PALETTE;
      roll = $urandom_range(0, 99);
      if (roll < 80) begin
        beat.entry_index = ENTRY_W'($urandom_range(0, n_eff - 1));
      end else if (roll < 88) begin
        beat.entry_index = ENTRY_W'(n_eff - 1);
      end else if (roll < 94) begin
        beat.entry_index = '0;
      end
    end
    return beat;
  endfunction

  // Offer one beat, after an optional idle stretch, and return once it is taken.
  task automatic send_beat(input crg_in_t beat);
    int gap;
    gap = ($urandom_range(0, 99) < feed_idle_pct) ? gap_cycles() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Let every outstanding palette request return, then let the block settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (IDLE_SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write both registers on consecutive cycles.
  task automatic apply_setup(input logic mode, input int size);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_INTERP_MODE;
    cfg_data  <= {(CFG_DATA_W-1)'($urandom), mode};
    @(negedge clk);
    cfg_index <= CFG_TABLE_ENTRIES;
    cfg_data  <= CFG_DATA_W'(size);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_phase(input logic mode, input int size, input int items,
                           input int feed_pct, input int sink_pct, input bit flood);
    int n_eff;
    n_eff = (size < 2) ? 2 : (size > MAX_ENTRIES) ? MAX_ENTRIES : size;
    wait_idle();
    apply_setup(mode, size);
    feed_idle_pct = feed_pct;
    sink_idle_pct = sink_pct;
    if (flood) flood_req = 1'b1;
    repeat (items) send_beat(random_beat(n_eff));
  endtask

  // Result side: random ready pattern, plus one long hold-off on request.
  initial begin : result_sink
    int run;
    bit flood_done;
    flood_done = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (flood_req && !flood_done) begin
        flood_done = 1'b1;
        out_ready <= 1'b0;
        run = HOLD_OFF_CYCLES;
      end else if ($urandom_range(0, 99) < sink_idle_pct) begin
        out_ready <= 1'b0;
        run = gap_cycles();
      end else begin
        out_ready <= 1'b1;
        run = $urandom_range(1, 16);
      end
      repeat (run) @(negedge clk);
    end
  end

  // Stimulus.
  initial begin : stimulus
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings and reset stops: all colors black.
    send_beat(entry_beat(0));
    send_beat(entry_beat(1023));
    // Edge positions, a saturated position and ignored stop numbers.
    send_beat(stop_beat(0, 0, 8'hff, 8'h00, 8'h00));
    send_beat(stop_beat(9, 'h1ffff, 8'h00, 8'hff, 8'hff));
    send_beat(stop_beat(12, 77, 8'hff, 8'hff, 8'hff));
    send_beat(stop_beat(15, 'h1ffff, 8'hff, 8'hff, 8'hff));
    send_beat(entry_beat(50));
    send_beat(entry_beat(100));
    // Two stops at one: the last entry lands on a zero-width segment.
    send_beat(stop_beat(8, ONE_Q16, 8'h80, 8'h40, 8'h20));
    send_beat(entry_beat(100));
    // Two coincident first stops: entry zero clamps onto a zero-width segment.
    send_beat(stop_beat(0, 5000, 8'hff, 8'h00, 8'h00));
    send_beat(stop_beat(1, 5000, 8'h00, 8'h00, 8'hff));
    send_beat(entry_beat(0));
    // Positions below the first stop clamp the blend to the left color.
    send_beat(stop_beat(1, 9000, 8'h00, 8'h00, 8'hff));
    send_beat(entry_beat(0));
    send_beat(entry_beat(1));
    send_beat(entry_beat(8));
    // Entry 50 of 101 sits exactly midway between these two stops.
    send_beat(stop_beat(4, 30000, 8'h10, 8'h20, 8'h30));
    send_beat(stop_beat(5, 35536, 8'hf0, 8'he0, 8'hd0));
    send_beat(entry_beat(50));

    // Nearest-stop mode: the midway entry takes the right stop.
    wait_idle();
    apply_setup(1'b0, 101);
    send_beat(entry_beat(50));
    send_beat(entry_beat(49));
    send_beat(entry_beat(1023));

    // Smallest palette.
    wait_idle();
    apply_setup(1'b0, 2);
    send_beat(entry_beat(0));
    send_beat(entry_beat(1));
    send_beat(entry_beat(1023));

    // Random phases over a spread of settings, extremes included.
    run_phase(1'b1, MAX_ENTRIES, 130, 40, 30, 1'b0);
    run_phase(1'b0, 2047, 130, 0, 0, 1'b0);
    run_phase(1'b1, 0, 100, 30, 40, 1'b0);
    run_phase(1'b1, 101, 140, 0, 20, 1'b1);
    run_phase(1'b0, 1, 100, 50, 50, 1'b0);
    run_phase(1'b1, 3, 120, 30, 30, 1'b0);
    run_phase(1'b0, MAX_ENTRIES, 120, 20, 60, 1'b0);
    run_phase(1'b1, $urandom_range(2, MAX_ENTRIES), 130, 40, 30, 1'b0);
    run_phase(1'($urandom), $urandom_range(0, 2047), 130, 30, 30, 1'b0);

    wait_idle();
    if (mismatches == 0) begin
      $display("** color_gradient_ramp: PASSED **");
    end else begin
      $display("** color_gradient_ramp: FAILED **");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run.
  initial begin : run_limit
    #8_000_000;
    $display("** color_gradient_ramp: FAILED **");
    $finish;
  end

endmodule

// ===== sim.f =====
src/crg_pkg.sv
src/crg_divider.sv
src/crg_datapath.sv
src/crg_ctrl.sv
src/color_gradient_ramp.sv
verif/crg_checker.sv
verif/testbench.sv
